>>> hw/rtl/bft_pkg.sv
package bft_pkg;

    localparam int FLOW_ENTRIES_DEF = 64;
    localparam int COUNTER_BITS_DEF = 32;
    localparam int OUT_CNT_W        = 32;
    localparam int UDP_HDR_BYTES    = 8;
    localparam int TCP_WORD_SHIFT   = 2;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_TCP   = 2'd1,
        KIND_UDP   = 2'd2,
        KIND_RSVD  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_INSERT,
        ST_OUT
    } state_t;

    // stored flow key: kind, version, addresses, ports
    typedef struct packed {
        logic [1:0]  kind;
        logic        v6;
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic [63:0] dst_hi;
        logic [63:0] dst_lo;
        logic [15:0] sport;
        logic [15:0] dport;
    } flow_key_t;

endpackage

>>> hw/rtl/bidirectional_flow_tracker.sv
// channel | valid    | ready    | payload
// in      | in_valid | in_ready | is_ipv6 .. tcp_data_offset
// out     | out_valid| out_ready| new_flow .. udp_flows_seen
// an item of other kind goes from accept straight to the result
// a tcp or udp item scans the stored flows, each with a memory read and a compare,
// and takes one insert step when no flow matches
// the scan stops early at the first match
// reset clears counters, fill level and control; the memory needs no clearing
// while a result waits for out_ready, no new item is taken
module bidirectional_flow_tracker
#(
    parameter int FLOW_ENTRIES = bft_pkg::FLOW_ENTRIES_DEF,
    parameter int COUNTER_BITS = bft_pkg::COUNTER_BITS_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        is_ipv6,
    input  logic [1:0]  l4_kind,
    input  logic [63:0] src_addr_hi,
    input  logic [63:0] src_addr_lo,
    input  logic [63:0] dst_addr_hi,
    input  logic [63:0] dst_addr_lo,
    input  logic [15:0] src_port,
    input  logic [15:0] dst_port,
    input  logic [15:0] ip_payload_len,
    input  logic [15:0] udp_length,
    input  logic [3:0]  tcp_data_offset,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        new_flow,
    output logic        table_full,
    output logic [5:0]  l4_header_len,
    output logic [15:0] l4_payload_len,
    output logic [31:0] packets_seen,
    output logic [31:0] tcp_packets_seen,
    output logic [31:0] udp_packets_seen,
    output logic [31:0] tcp_byte_total,
    output logic [31:0] udp_byte_total,
    output logic [31:0] flows_seen,
    output logic [31:0] tcp_flows_seen,
    output logic [31:0] udp_flows_seen
);

    import bft_pkg::*;

    localparam int IDX_W  = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int FILL_W = $clog2(FLOW_ENTRIES + 1);
    localparam int CW     = COUNTER_BITS;
    localparam logic [CW-1:0] CMAX = {CW{1'b1}};

    state_t state_reg, state_next;

    flow_key_t mem [FLOW_ENTRIES];
    flow_key_t rd_reg;
    flow_key_t key_reg;

    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] idx_reg, idx_next;
    logic              new_reg, full_reg;
    logic [5:0]        hdr_reg;
    logic [15:0]       pay_reg;
    logic [CW-1:0]     pkt_reg, tpkt_reg, upkt_reg, tbyte_reg, ubyte_reg;
    logic [CW-1:0]     flow_reg, tflow_reg, uflow_reg;

    logic accept, hit, is_l4, do_ins;
    flow_key_t key_in;
    logic [15:0] byte_add;
    logic [5:0]  hdr_in;
    logic [15:0] pay_in;

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] c,
                                              input logic [15:0] a);
        logic [CW:0] s;
        begin
            s = {1'b0, c} + (CW+1)'(a);
            sat_add = s[CW] ? CMAX : s[CW-1:0];
        end
    endfunction

    assign accept = in_valid && in_ready;
    assign is_l4  = (l4_kind == KIND_TCP) || (l4_kind == KIND_UDP);

    always_comb
    begin
        key_in.kind   = l4_kind;
        key_in.v6     = is_ipv6;
        key_in.src_hi = is_ipv6 ? src_addr_hi : 64'd0;
        key_in.src_lo = is_ipv6 ? src_addr_lo : {32'd0, src_addr_lo[31:0]};
        key_in.dst_hi = is_ipv6 ? dst_addr_hi : 64'd0;
        key_in.dst_lo = is_ipv6 ? dst_addr_lo : {32'd0, dst_addr_lo[31:0]};
        key_in.sport  = src_port;
        key_in.dport  = dst_port;
        if (l4_kind == KIND_TCP)
        begin
            hdr_in   = {tcp_data_offset, 2'b00};
            pay_in   = (ip_payload_len > 16'(hdr_in)) ? ip_payload_len - 16'(hdr_in) : 16'd0;
            byte_add = ip_payload_len;
        end
        else
        begin
            hdr_in   = 6'(UDP_HDR_BYTES);
            pay_in   = (udp_length > 16'(UDP_HDR_BYTES)) ?
                       udp_length - 16'(UDP_HDR_BYTES) : 16'd0;
            byte_add = is_ipv6 ? ip_payload_len : udp_length;
        end
    end

    always_comb
    begin
        hit = (rd_reg.kind == key_reg.kind) && (rd_reg.v6 == key_reg.v6) &&
              (((rd_reg.src_hi == key_reg.src_hi) && (rd_reg.src_lo == key_reg.src_lo) &&
                (rd_reg.dst_hi == key_reg.dst_hi) && (rd_reg.dst_lo == key_reg.dst_lo) &&
                (rd_reg.sport == key_reg.sport) && (rd_reg.dport == key_reg.dport)) ||
               ((rd_reg.src_hi == key_reg.dst_hi) && (rd_reg.src_lo == key_reg.dst_lo) &&
                (rd_reg.dst_hi == key_reg.src_hi) && (rd_reg.dst_lo == key_reg.src_lo) &&
                (rd_reg.sport == key_reg.dport) && (rd_reg.dport == key_reg.sport)));
        do_ins = (state_reg == ST_INSERT) && (fill_reg < FILL_W'(FLOW_ENTRIES));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next = '0;
                    if (!is_l4)
                        state_next = ST_OUT;
                    else if (fill_reg == '0)
                        state_next = ST_INSERT;
                    else
                        state_next = ST_READ;
                end
            end
            ST_READ:
                state_next = ST_CMP;
            ST_CMP:
            begin
                if (hit)
                    state_next = ST_OUT;
                else if (idx_reg + FILL_W'(1) >= fill_reg)
                    state_next = ST_INSERT;
                else
                begin
                    idx_next   = idx_reg + FILL_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_INSERT:
                state_next = ST_OUT;
            ST_OUT:
                if (out_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_OUT);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
            rd_reg <= mem[idx_reg[IDX_W-1:0]];
        if (do_ins)
            mem[fill_reg[IDX_W-1:0]] <= key_reg;
        if (accept)
        begin
            key_reg <= key_in;
            hdr_reg <= is_l4 ? hdr_in : 6'd0;
            pay_reg <= is_l4 ? pay_in : 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            fill_reg  <= '0;
            new_reg   <= 1'b0;
            full_reg  <= 1'b0;
            pkt_reg   <= '0;
            tpkt_reg  <= '0;
            upkt_reg  <= '0;
            tbyte_reg <= '0;
            ubyte_reg <= '0;
            flow_reg  <= '0;
            tflow_reg <= '0;
            uflow_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (accept)
            begin
                new_reg  <= 1'b0;
                full_reg <= 1'b0;
                pkt_reg  <= sat_add(pkt_reg, 16'd1);
                if (l4_kind == KIND_TCP)
                begin
                    tpkt_reg  <= sat_add(tpkt_reg, 16'd1);
                    tbyte_reg <= sat_add(tbyte_reg, byte_add);
                end
                if (l4_kind == KIND_UDP)
                begin
                    upkt_reg  <= sat_add(upkt_reg, 16'd1);
                    ubyte_reg <= sat_add(ubyte_reg, byte_add);
                end
            end
            if (state_reg == ST_INSERT)
            begin
                if (do_ins)
                begin
                    fill_reg <= fill_reg + FILL_W'(1);
                    new_reg  <= 1'b1;
                    flow_reg <= sat_add(flow_reg, 16'd1);
                    if (key_reg.kind == KIND_TCP)
                        tflow_reg <= sat_add(tflow_reg, 16'd1);
                    else
                        uflow_reg <= sat_add(uflow_reg, 16'd1);
                end
                else
                    full_reg <= 1'b1;
            end
        end
    end

    assign new_flow         = new_reg;
    assign table_full       = full_reg;
    assign l4_header_len    = hdr_reg;
    assign l4_payload_len   = pay_reg;
    assign packets_seen     = OUT_CNT_W'(pkt_reg);
    assign tcp_packets_seen = OUT_CNT_W'(tpkt_reg);
    assign udp_packets_seen = OUT_CNT_W'(upkt_reg);
    assign tcp_byte_total   = OUT_CNT_W'(tbyte_reg);
    assign udp_byte_total   = OUT_CNT_W'(ubyte_reg);
    assign flows_seen       = OUT_CNT_W'(flow_reg);
    assign tcp_flows_seen   = OUT_CNT_W'(tflow_reg);
    assign udp_flows_seen   = OUT_CNT_W'(uflow_reg);

endmodule
